>>> rtl/olap_pkg.sv
// Shared constants for the overlap layer assigner.
package olap_pkg;

    localparam int PREV_BITS    = 9;
    localparam int CHUNK_LOG    = 3;
    localparam int SEARCH_CHUNK = 1 << CHUNK_LOG;

endpackage

>>> rtl/olap_rect_if.sv
// Input channel: one rectangle item with its previous layer.
interface olap_rect_if #(
    parameter int COORD_BITS = 16
);
    import olap_pkg::*;

    logic                           valid;
    logic                           ready;
    logic                           frame_start;
    logic signed [COORD_BITS-1:0]   rect_x;
    logic signed [COORD_BITS-1:0]   rect_y;
    logic        [COORD_BITS-1:0]   rect_w;
    logic        [COORD_BITS-1:0]   rect_h;
    logic signed [PREV_BITS-1:0]    prev_class;

    modport source (
        output valid, frame_start, rect_x, rect_y, rect_w, rect_h, prev_class,
        input  ready
    );

    modport sink (
        input  valid, frame_start, rect_x, rect_y, rect_w, rect_h, prev_class,
        output ready
    );
endinterface

>>> rtl/olap_result_if.sv
// Output channel: assigned layer of one item.
interface olap_result_if #(
    parameter int LAYER_BITS = 8
);
    logic                   valid;
    logic                   ready;
    logic [LAYER_BITS-1:0]  layer;
    logic                   kept_previous;
    logic                   overflow;

    modport source (
        output valid, layer, kept_previous, overflow,
        input  ready
    );

    modport sink (
        input  valid, layer, kept_previous, overflow,
        output ready
    );
endinterface

>>> rtl/overlap_layer_assigner.sv
// Overlap layer assigner: greedy layer assignment of rectangles within a frame.
// Each accepted item goes through a scan of the N stored items, a search for a free layer in
// chunks of eight layers, and a done state that hands off the result; an overflow item skips
// the scan and search. Throughput: one item at a time; a held result stalls the next item.
// The scan reads one rectangle per cycle.
// Reset empties the store (count zero); memory contents are not cleared.
module overlap_layer_assigner #(
    parameter int MAX_ITEMS  = 64,
    parameter int COORD_BITS = 16,
    parameter int LAYER_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    olap_rect_if.sink             rect,
    olap_result_if.source         result
);
    import olap_pkg::*;

    localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W  = $clog2(MAX_ITEMS);
    localparam int NCHUNK  = (MAX_ITEMS + SEARCH_CHUNK - 1) / SEARCH_CHUNK;
    localparam int CHK_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int SIDX_W  = CHK_W + CHUNK_LOG;
    localparam int TAKEN_W = NCHUNK * SEARCH_CHUNK;
    localparam int EXT_W   = COORD_BITS + 2;
    localparam int CMP_W   = SIDX_W + LAYER_BITS;

    localparam logic [16:0]         NUM_LAYERS_EXT = 17'(1) << LAYER_BITS;
    localparam logic [LAYER_BITS-1:0] LAYER_TOP    = {LAYER_BITS{1'b1}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [EXT_W-1:0]      xr;
        logic signed [EXT_W-1:0]      yb;
        logic                         empty;
        logic [LAYER_BITS-1:0]        layer;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SEARCH,
        ST_DONE
    } state_t;

    function automatic logic [CHUNK_LOG:0] first_zero(input logic [SEARCH_CHUNK-1:0] bits);
        logic [CHUNK_LOG:0] res;
        res = '0;
        for (int i = SEARCH_CHUNK - 1; i >= 0; i--)
        begin
            if (!bits[i])
            begin
                res = {1'b1, CHUNK_LOG'(i)};
            end
        end
        return res;
    endfunction

    entry_t mem [MAX_ITEMS];

    state_t                                   state_reg, state_next;
    entry_t                                   cur_reg, cur_next;
    logic [LAYER_BITS-1:0]                    prev_reg, prev_next;
    logic                                     prev_ok_reg, prev_ok_next;
    logic                                     prev_hit_reg, prev_hit_next;
    logic                                     ovf_reg, ovf_next;
    logic [CNT_W-1:0]                         count_reg, count_next;
    logic [CNT_W-1:0]                         issue_reg, issue_next;
    logic                                     rd_vld_reg;
    entry_t                                   rd_data_reg;
    logic [NCHUNK-1:0][SEARCH_CHUNK-1:0]      taken_reg, taken_next;
    logic [CHK_W-1:0]                         chunk_reg, chunk_next;
    logic [LAYER_BITS-1:0]                    chosen_reg, chosen_next;
    logic                                     kept_reg, kept_next;
    logic                                     out_valid_reg, out_valid_next;
    logic [LAYER_BITS-1:0]                    out_layer_reg, out_layer_next;
    logic                                     out_kept_reg, out_kept_next;
    logic                                     out_ovf_reg, out_ovf_next;

    logic                      in_fire;
    logic                      rd_en;
    logic                      wr_en;
    logic                      meet;
    logic [CNT_W-1:0]          count_eff;
    logic [CHUNK_LOG:0]        fz;
    logic [SIDX_W-1:0]         cand;
    logic [SIDX_W-1:0]         mark_idx;
    logic signed [EXT_W-1:0]   cur_x_ext, cur_y_ext, rd_x_ext, rd_y_ext;

    assign rect.ready    = (state_reg == ST_IDLE);
    assign in_fire       = rect.valid && rect.ready;
    assign rd_en         = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign wr_en         = (state_reg == ST_DONE) && !ovf_reg
                           && (!out_valid_reg || result.ready);

    assign result.valid         = out_valid_reg;
    assign result.layer         = out_layer_reg;
    assign result.kept_previous = out_kept_reg;
    assign result.overflow      = out_ovf_reg;

    assign cur_x_ext = EXT_W'(cur_reg.x);
    assign cur_y_ext = EXT_W'(cur_reg.y);
    assign rd_x_ext  = EXT_W'(rd_data_reg.x);
    assign rd_y_ext  = EXT_W'(rd_data_reg.y);

    assign meet = !cur_reg.empty && !rd_data_reg.empty
                  && (cur_x_ext < rd_data_reg.xr) && (rd_x_ext < cur_reg.xr)
                  && (cur_y_ext < rd_data_reg.yb) && (rd_y_ext < cur_reg.yb);

    assign mark_idx  = SIDX_W'(rd_data_reg.layer);
    assign count_eff = rect.frame_start ? '0 : count_reg;
    assign fz        = first_zero(taken_reg[chunk_reg]);
    assign cand      = {chunk_reg, fz[CHUNK_LOG-1:0]};

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_ok_next   = prev_ok_reg;
        prev_hit_next  = prev_hit_reg;
        ovf_next       = ovf_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        taken_next     = taken_reg;
        chunk_next     = chunk_reg;
        chosen_next    = chosen_reg;
        kept_next      = kept_reg;
        out_valid_next = out_valid_reg;
        out_layer_next = out_layer_reg;
        out_kept_next  = out_kept_reg;
        out_ovf_next   = out_ovf_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (rd_vld_reg && meet)
        begin
            if (rd_data_reg.layer == prev_reg)
            begin
                prev_hit_next = 1'b1;
            end
            if (CMP_W'(rd_data_reg.layer) < CMP_W'(TAKEN_W))
            begin
                taken_next[mark_idx[SIDX_W-1:CHUNK_LOG]][mark_idx[CHUNK_LOG-1:0]] = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cur_next.x     = rect.rect_x;
                    cur_next.y     = rect.rect_y;
                    cur_next.xr    = EXT_W'(rect.rect_x) + EXT_W'({2'b00, rect.rect_w});
                    cur_next.yb    = EXT_W'(rect.rect_y) + EXT_W'({2'b00, rect.rect_h});
                    cur_next.empty = (rect.rect_w == '0) || (rect.rect_h == '0);
                    cur_next.layer = '0;
                    prev_next      = LAYER_BITS'(rect.prev_class[PREV_BITS-2:0]);
                    prev_ok_next   = !rect.prev_class[PREV_BITS-1]
                                     && (17'(rect.prev_class[PREV_BITS-2:0]) < NUM_LAYERS_EXT);
                    prev_hit_next  = 1'b0;
                    count_next     = count_eff;
                    issue_next     = '0;
                    taken_next     = '0;
                    chunk_next     = '0;
                    if (count_eff >= CNT_W'(MAX_ITEMS))
                    begin
                        ovf_next    = 1'b1;
                        chosen_next = '0;
                        kept_next   = 1'b0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        ovf_next   = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                if (prev_ok_reg && !prev_hit_reg)
                begin
                    chosen_next = prev_reg;
                    kept_next   = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (fz[CHUNK_LOG])
                begin
                    chosen_next = (CMP_W'(cand) > CMP_W'(LAYER_TOP)) ? LAYER_TOP
                                                                     : LAYER_BITS'(cand);
                    kept_next   = 1'b0;
                    state_next  = ST_DONE;
                end
                else if (chunk_reg == CHK_W'(NCHUNK - 1))
                begin
                    chosen_next = LAYER_TOP;
                    kept_next   = 1'b0;
                    state_next  = ST_DONE;
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_layer_next = chosen_reg;
                    out_kept_next  = kept_reg;
                    out_ovf_next   = ovf_reg;
                    if (!ovf_reg)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            prev_reg      <= '0;
            prev_ok_reg   <= 1'b0;
            prev_hit_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            count_reg     <= '0;
            issue_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            taken_reg     <= '0;
            chunk_reg     <= '0;
            chosen_reg    <= '0;
            kept_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_layer_reg <= '0;
            out_kept_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            prev_ok_reg   <= prev_ok_next;
            prev_hit_reg  <= prev_hit_next;
            ovf_reg       <= ovf_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= rd_en;
            taken_reg     <= taken_next;
            chunk_reg     <= chunk_next;
            chosen_reg    <= chosen_next;
            kept_reg      <= kept_next;
            out_valid_reg <= out_valid_next;
            out_layer_reg <= out_layer_next;
            out_kept_reg  <= out_kept_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    // item memory: one read port for the scan, one write port at item end
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= '{x:     cur_reg.x,
                                            y:     cur_reg.y,
                                            xr:    cur_reg.xr,
                                            yb:    cur_reg.yb,
                                            empty: cur_reg.empty,
                                            layer: chosen_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[issue_reg[ADDR_W-1:0]];
        end
    end

endmodule

>>> sim/overlap_layer_assigner_tb.sv
// Self-checking testbench for overlap_layer_assigner against a greedy layer predictor.
module overlap_layer_assigner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import olap_pkg::*;

    localparam int MAX_ITEMS   = 64;
    localparam int COORD_BITS  = 16;
    localparam int LAYER_BITS  = 8;
    localparam int NUM_LAYERS  = 1 << LAYER_BITS;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_ITEMS = 1450;

    typedef struct {
        longint x;
        longint y;
        longint w;
        longint h;
    } frame_box_t;

    typedef struct {
        logic [LAYER_BITS-1:0] layer;
        logic                  kept_previous;
        logic                  overflow;
    } layer_result_t;

    logic clk;
    logic rst_n;

    olap_rect_if   #(.COORD_BITS(COORD_BITS)) rect_ch ();
    olap_result_if #(.LAYER_BITS(LAYER_BITS)) result_ch ();

    overlap_layer_assigner #(
        .MAX_ITEMS  (MAX_ITEMS),
        .COORD_BITS (COORD_BITS),
        .LAYER_BITS (LAYER_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rect   (rect_ch),
        .result (result_ch)
    );

    // predictor copy of the frame store
    frame_box_t            frame_boxes  [MAX_ITEMS];
    logic [LAYER_BITS-1:0] frame_layers [MAX_ITEMS];
    int                    frame_count;

    layer_result_t expected_assignments [$];

    int src_idle_pct;
    int snk_stall_pct;
    int cycle_count;
    int error_count;
    int items_sent;
    int results_checked;
    int overflow_seen;
    int kept_seen;
    int top_layer_seen;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d results still pending",
                         cycle_count, expected_assignments.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic bit boxes_overlap(input frame_box_t a, input frame_box_t b);
        if (a.w == 0 || a.h == 0 || b.w == 0 || b.h == 0)
            return 1'b0;
        return a.x < b.x + b.w && b.x < a.x + a.w &&
               a.y < b.y + b.h && b.y < a.y + a.h;
    endfunction

    function automatic layer_result_t greedy_layer(
        input bit                            fs,
        input logic signed [COORD_BITS-1:0]  x,
        input logic signed [COORD_BITS-1:0]  y,
        input logic        [COORD_BITS-1:0]  w,
        input logic        [COORD_BITS-1:0]  h,
        input logic signed [PREV_BITS-1:0]   prev
    );
        bit            taken [NUM_LAYERS];
        frame_box_t    cur;
        layer_result_t r;
        r.layer         = '1;
        r.kept_previous = 1'b0;
        r.overflow      = 1'b0;
        if (fs)
            frame_count = 0;
        if (frame_count >= MAX_ITEMS)
        begin
            r.layer    = '0;
            r.overflow = 1'b1;
            return r;
        end
        cur.x = x;
        cur.y = y;
        cur.w = w;
        cur.h = h;
        for (int k = 0; k < NUM_LAYERS; k++)
            taken[k] = 1'b0;
        for (int i = 0; i < frame_count; i++)
            if (boxes_overlap(cur, frame_boxes[i]))
                taken[frame_layers[i]] = 1'b1;
        if (prev >= 0 && prev < NUM_LAYERS && !taken[prev])
        begin
            r.layer         = prev[LAYER_BITS-1:0];
            r.kept_previous = 1'b1;
        end
        else
        begin
            for (int k = 0; k < NUM_LAYERS; k++)
                if (!taken[k])
                begin
                    r.layer = LAYER_BITS'(k);
                    break;
                end
        end
        frame_boxes[frame_count]  = cur;
        frame_layers[frame_count] = r.layer;
        frame_count++;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 30)
            $display("MISMATCH cycle %0d result %0d: %s", cycle_count, results_checked, msg);
    endtask

    task automatic check_assignment();
        layer_result_t want;
        if (expected_assignments.size() == 0)
        begin
            report_mismatch("result with no item pending");
            return;
        end
        want = expected_assignments.pop_front();
        if (result_ch.layer !== want.layer)
            report_mismatch($sformatf("layer %0d, expected %0d", result_ch.layer, want.layer));
        if (result_ch.kept_previous !== want.kept_previous)
            report_mismatch($sformatf("kept_previous %b, expected %b",
                                      result_ch.kept_previous, want.kept_previous));
        if (result_ch.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, expected %b",
                                      result_ch.overflow, want.overflow));
        results_checked++;
        if (result_ch.overflow === 1'b1)
            overflow_seen++;
        if (result_ch.kept_previous === 1'b1)
            kept_seen++;
        if (result_ch.layer > top_layer_seen)
            top_layer_seen = result_ch.layer;
    endtask

    // result side: random backpressure, check on every accepted item
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                check_assignment();
            result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_rect(
        input bit                            fs,
        input logic signed [COORD_BITS-1:0]  x,
        input logic signed [COORD_BITS-1:0]  y,
        input logic        [COORD_BITS-1:0]  w,
        input logic        [COORD_BITS-1:0]  h,
        input logic signed [PREV_BITS-1:0]   prev
    );
        while ($urandom_range(99) < src_idle_pct)
        begin
            rect_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rect_ch.valid       <= 1'b1;
        rect_ch.frame_start <= fs;
        rect_ch.rect_x      <= x;
        rect_ch.rect_y      <= y;
        rect_ch.rect_w      <= w;
        rect_ch.rect_h      <= h;
        rect_ch.prev_class  <= prev;
        do
            @(posedge clk);
        while (!(rect_ch.valid === 1'b1 && rect_ch.ready === 1'b1));
        expected_assignments.push_back(greedy_layer(fs, x, y, w, h, prev));
        items_sent++;
    endtask

    task automatic send_random_rect(input bit fs);
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic        [COORD_BITS-1:0] w;
        logic        [COORD_BITS-1:0] h;
        logic signed [PREV_BITS-1:0]  prev;
        int                           pick;
        pick = $urandom_range(15);
        if (pick == 0)
        begin
            x = COORD_BITS'($urandom);
            y = COORD_BITS'($urandom);
            w = COORD_BITS'($urandom);
            h = COORD_BITS'($urandom);
        end
        else
        begin
            x = COORD_BITS'($urandom_range(240) - 120);
            y = COORD_BITS'($urandom_range(240) - 120);
            w = ($urandom_range(11) == 0) ? '0 : COORD_BITS'($urandom_range(1, 90));
            h = ($urandom_range(11) == 0) ? '0 : COORD_BITS'($urandom_range(1, 90));
        end
        pick = $urandom_range(99);
        if (pick < 20)
            prev = PREV_BITS'(-1);
        else if (pick < 30)
            prev = PREV_BITS'($urandom);
        else if (pick < 80)
            prev = PREV_BITS'($urandom_range(0, 10));
        else
            prev = PREV_BITS'($urandom_range(0, 70));
        send_rect(fs, x, y, w, h, prev);
    endtask

    // hold the sender until every pending result is back
    task automatic wait_drained();
        rect_ch.valid <= 1'b0;
        while (expected_assignments.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int src, input int snk);
        src_idle_pct  = src;
        snk_stall_pct = snk;
    endtask

    task automatic test_directed_edges();
        set_idling(0, 0);
        send_rect(1, -32768, -32768, 16'hFFFF, 16'hFFFF, -1);
        send_rect(0, -32768, -32768, 16'hFFFF, 16'hFFFF, -1);
        // touches right edge of the big boxes only
        send_rect(0, 32767, -32768, 1, 1, 0);
        send_rect(0, 0, 0, 0, 100, 0);
        send_rect(0, 0, 0, 100, 0, -256);
        send_rect(0, 0, 0, 10, 10, 255);
        send_rect(0, 5, 5, 10, 10, 255);
        send_rect(0, 5, 5, 10, 10, 0);
        send_rect(0, 10, 0, 10, 10, 2);
        send_rect(0, 0, 10, 10, 10, 3);
        send_rect(0, 9, 9, 1, 1, 3);
        send_rect(0, 32767, 32767, 16'hFFFF, 16'hFFFF, -128);
        send_rect(1, 32767, 32767, 16'hFFFF, 16'hFFFF, 3);
        send_rect(0, 32767, 32767, 1, 1, 3);
        send_rect(0, -1, -1, 16'h8000, 16'h8000, 170);
        send_rect(0, 21845, -21846, 16'h5555, 16'hAAAA, 85);
        send_rect(0, -21846, 21845, 16'hAAAA, 16'h5555, 85);
        send_rect(1, 0, 0, 1, 1, 1);
        send_rect(0, 0, 0, 1, 1, 1);
        send_rect(0, 0, 0, 1, 1, 1);
        wait_drained();
    endtask

    task automatic test_store_full();
        set_idling(34, 34);
        // identical boxes stack onto layers 0..63, then spill past capacity
        for (int i = 0; i < MAX_ITEMS; i++)
            send_rect(i == 0, 0, 0, 16, 16, -1);
        for (int i = 0; i < 3; i++)
            send_random_rect(0);
        send_random_rect(1);
        for (int i = 1; i < MAX_ITEMS + 2; i++)
            send_random_rect(0);
        send_random_rect(1);
        wait_drained();
    endtask

    task automatic test_random_frames(input int n_items, input int src, input int snk);
        int target;
        int len;
        set_idling(src, snk);
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 30);
            for (int i = 0; i < len && items_sent < target; i++)
                send_random_rect(i == 0);
        end
        wait_drained();
        repeat ($urandom_range(1, 5)) @(posedge clk);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        rect_ch.valid       = 1'b0;
        rect_ch.frame_start = 1'b0;
        rect_ch.rect_x      = '0;
        rect_ch.rect_y      = '0;
        rect_ch.rect_w      = '0;
        rect_ch.rect_h      = '0;
        rect_ch.prev_class  = '0;
        src_idle_pct        = 0;
        snk_stall_pct       = 0;
        error_count         = 0;
        items_sent          = 0;
        results_checked     = 0;
        overflow_seen       = 0;
        kept_seen           = 0;
        top_layer_seen      = 0;
        frame_count         = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_store_full();
        test_random_frames(RANDOM_ITEMS / 4, 0, 0);
        test_random_frames(RANDOM_ITEMS / 4, 50, 0);
        test_random_frames(RANDOM_ITEMS / 4, 0, 50);
        test_random_frames(RANDOM_ITEMS / 4, 34, 34);

        wait_drained();
        repeat (MAX_ITEMS + 16) @(posedge clk);

        $display("Sent %0d rectangles over directed, full-store and random frames", items_sent);
        $display("Checked %0d results: %0d kept, %0d overflow, top layer %0d, %0d mismatches",
                 results_checked, kept_seen, overflow_seen, top_layer_seen, error_count);
        if (error_count == 0 && expected_assignments.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
